[rtl/integer_to_ascii_radix_defines.svh]
// Assertion macros for the integer-to-text RTL.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define ITA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset
`define ITA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ITA_ASSERT_IMP(lbl, ante, cons, msg)
`define ITA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/ita_pkg.sv]
// Package: widths, character codes, sequencer states and divider control types.
package ita_pkg;

  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 6;
  localparam int MAX_DIGITS = 32;
  localparam int PTR_W      = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ita_state_t;

  // Divider request and status
  typedef struct packed {
    logic start;
  } ita_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ita_div_sts_t;

  // Digit value to lowercase ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      digit_char = CH_A + CHAR_W'(d - 4'd10);
    end
  endfunction

endpackage

[rtl/integer_to_ascii_radix.sv]
// Top level: signed 32-bit integer to ASCII text in radix 2..16, one character per item.
// Each digit is one division in the single bit-serial divider (32 steps).
// All digits are computed first; then any minus sign, then digits most significant first.
// Characters leave at one per cycle while out_ready stays high.
// A new input item is accepted only in idle, after its last character is loaded for output.
// Synchronous active-low reset clears control state and sets radix to 10.
`include "integer_to_ascii_radix_defines.svh"

module integer_to_ascii_radix (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ita_pkg::RADIX_W-1:0]         cfg_radix,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ita_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ita_pkg::CHAR_W-1:0]          out_character,
  output logic [ita_pkg::LEN_W-1:0]           out_length,
  output logic                                out_last
);

  ita_pkg::ita_state_t state_r, state_nxt;

  logic [ita_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [ita_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [ita_pkg::LEN_W-1:0]   ptr_r, ptr_nxt;
  logic [ita_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                        neg_r, neg_nxt;
  logic                        sign_pend_r, sign_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ita_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [ita_pkg::LEN_W-1:0]   out_len_r, out_len_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [ita_pkg::DIGIT_W-1:0] digits_r [ita_pkg::MAX_DIGITS];

  ita_pkg::ita_div_ctl_t       div_ctl;
  ita_pkg::ita_div_sts_t       div_sts;
  logic [ita_pkg::VALUE_W-1:0] div_dividend;
  logic [ita_pkg::VALUE_W-1:0] div_quo;
  logic [ita_pkg::DIGIT_W-1:0] div_rem;

  logic                        in_acc;
  logic                        in_neg;
  logic [ita_pkg::VALUE_W-1:0] val_u;
  logic [ita_pkg::VALUE_W-1:0] mag;
  logic                        digit_done;
  logic                        quo_zero;
  logic                        load;
  logic [ita_pkg::LEN_W-1:0]   ptr_m1;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ita_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Sign handling: base 10 shows a minus sign, other bases read the bits unsigned
  assign val_u  = in_value;
  assign in_neg = (radix_r == ita_pkg::RADIX_DEC) && val_u[ita_pkg::VALUE_W-1];
  assign mag    = in_neg ? (~val_u + 1'b1) : val_u;

  assign digit_done = (state_r == ita_pkg::ST_DIV) && div_sts.done;
  assign quo_zero   = (div_quo == '0);
  assign load       = (state_r == ita_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign ptr_m1     = ptr_r - 1'b1;

  // Divider restarts on the quotient until it reaches zero
  assign div_ctl.start = in_acc || (digit_done && !quo_zero);
  assign div_dividend  = in_acc ? mag : div_quo;

  ita_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ita_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ita_pkg::ST_DIV;
      end
      ita_pkg::ST_DIV: begin
        if (digit_done && quo_zero) state_nxt = ita_pkg::ST_EMIT;
      end
      ita_pkg::ST_EMIT: begin
        if (load && !sign_pend_r && (ptr_r == ita_pkg::LEN_W'(1))) begin
          state_nxt = ita_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ita_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    radix_nxt     = radix_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    // Radix write, clamped to 2..16
    if (cfg_valid && cfg_ready) begin
      if (cfg_radix < ita_pkg::RADIX_MIN) begin
        radix_nxt = ita_pkg::RADIX_MIN;
      end else if (cfg_radix > ita_pkg::RADIX_MAX) begin
        radix_nxt = ita_pkg::RADIX_MAX;
      end else begin
        radix_nxt = cfg_radix;
      end
    end

    case (state_r)
      ita_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          neg_nxt = in_neg;
        end
      end
      ita_pkg::ST_DIV: begin
        if (digit_done) begin
          cnt_nxt = cnt_r + 1'b1;
          if (quo_zero) begin
            ptr_nxt       = cnt_r + 1'b1;
            len_nxt       = cnt_r + 1'b1 + ita_pkg::LEN_W'(neg_r);
            sign_pend_nxt = neg_r;
          end
        end
      end
      ita_pkg::ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = len_r;
          if (sign_pend_r) begin
            out_char_nxt  = ita_pkg::CH_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ita_pkg::digit_char(digits_r[ptr_m1[ita_pkg::PTR_W-1:0]]);
            out_last_nxt = (ptr_r == ita_pkg::LEN_W'(1));
            ptr_nxt      = ptr_m1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ita_pkg::ST_IDLE;
      radix_r     <= ita_pkg::RADIX_RESET;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer, least significant digit first
  always_ff @(posedge clk) begin
    if (digit_done) begin
      digits_r[cnt_r[ita_pkg::PTR_W-1:0]] <= div_rem;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_length    = out_len_r;
  assign out_last      = out_last_r;

  // Checks
  `ITA_ASSERT_IMP(a_radix_range, 1'b1, (radix_r >= ita_pkg::RADIX_MIN) && (radix_r <= ita_pkg::RADIX_MAX), "radix register out of range")
  `ITA_ASSERT_IMP(a_idle_div_quiet, state_r == ita_pkg::ST_IDLE, !div_sts.busy && !div_sts.done, "divider active while idle")
  `ITA_ASSERT_IMP(a_done_in_div, div_sts.done, state_r == ita_pkg::ST_DIV, "divider result outside digit phase")
  `ITA_ASSERT_IMP(a_emit_has_chars, state_r == ita_pkg::ST_EMIT, ptr_r != '0, "emit phase with no digits left")
  `ITA_ASSERT_NXT(a_digit_count, digit_done, cnt_r <= ita_pkg::LEN_W'(ita_pkg::MAX_DIGITS), "digit count overflow")

endmodule

[rtl/ita_div.sv]
// Bit-serial restoring divider: 32-bit dividend by a 2..16 radix, one bit a cycle.
module ita_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ita_pkg::ita_div_ctl_t               ctl,
  input  logic [ita_pkg::VALUE_W-1:0]         dividend,
  input  logic [ita_pkg::RADIX_W-1:0]         divisor,
  output ita_pkg::ita_div_sts_t               sts,
  output logic [ita_pkg::VALUE_W-1:0]         quotient,
  output logic [ita_pkg::DIGIT_W-1:0]         remainder
);

  logic [ita_pkg::VALUE_W-1:0] quo_r, quo_nxt;
  logic [ita_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [ita_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [ita_pkg::RADIX_W-1:0] trial;
  logic [ita_pkg::RADIX_W-1:0] diff;
  logic                        ge;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[ita_pkg::VALUE_W-1]};
  assign ge    = (trial >= divisor);
  assign diff  = trial - divisor;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ita_pkg::VALUE_W-2:0], ge};
      rem_nxt = ge ? diff[ita_pkg::DIGIT_W-1:0] : trial[ita_pkg::DIGIT_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ita_pkg::STEP_W'(ita_pkg::VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
